// ===== hw/rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the msb-first bit field reader.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// stream word width and derived widths
	localparam int WORD_BITS = 32;
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int FIELD_MAX = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int N_W       = $clog2(FIELD_MAX + 1);
	localparam int CNT_W     = ((POS_W + 1) > N_W) ? (POS_W + 1) : N_W;
	localparam int SH_W      = $clog2(2 * WORD_BITS) + 1;

	// port field widths
	localparam int OP_W    = 1;
	localparam int FW_W    = 6;
	localparam int NWORD_W = 32;
	localparam int VALUE_W = 32;

	// operation codes on the request channel
	localparam logic [OP_W-1:0] OP_READ = 1'b0;
	localparam logic [OP_W-1:0] OP_PAD  = 1'b1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// item class decided by the front part
	typedef enum logic [1:0] {
		KIND_SKIP = 2'd0,
		KIND_PAD  = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	// classified item as it travels through the queue
	typedef struct packed {
		kind_t                kind;
		logic [N_W-1:0]       width;
		logic [WORD_BITS-1:0] word;
		logic                 avail;
	} cmd_t;

endpackage

// ===== hw/rtl/bfr_req_if.sv =====
// ----------------------------------------------------------------------------
// bfr_req_if
// Request channel: operation, field width and the offered stream word.
// ----------------------------------------------------------------------------
interface bfr_req_if import bfr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [FW_W-1:0]    field_width;
	logic [NWORD_W-1:0] next_word;
	logic               word_available;

	modport source (
		output valid, operation, field_width, next_word, word_available,
		input  ready
	);
	modport sink (
		input  valid, operation, field_width, next_word, word_available,
		output ready
	);
endinterface

// ===== hw/rtl/bfr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfr_rsp_if
// Result channel: extracted field and stream status flags.
// ----------------------------------------------------------------------------
interface bfr_rsp_if import bfr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] field_value;
	logic               word_taken;
	logic               ran_out;

	modport source (
		output valid, field_value, word_taken, ran_out,
		input  ready
	);
	modport sink (
		input  valid, field_value, word_taken, ran_out,
		output ready
	);
endinterface

// ===== hw/rtl/bit_field_reader_unit.sv =====
// ----------------------------------------------------------------------------
// bit_field_reader_unit
// MSB-first field reader over a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: operation (read or pad), field_width
//   (1 to 32, larger values saturate, zero is a no-op), the next stream word
//   and its availability flag. rsp returns exactly one result per item:
//   field_value right-aligned, word_taken when the offered word was consumed,
//   ran_out when a needed word was missing (missing bits read as zero).
//   A source should offer the same stream word again until word_taken is seen.
//   Path: an accepted item is held in a queue entry, and its result is then
//   registered in the back part's result register.
//   Throughput: one item per cycle while rsp is taken; the front classifies,
//   a two-entry queue decouples it from the back, whose shift of the held
//   word and bit position bounds the rate.
//   Stall: when rsp is not taken the result register holds, the queue fills,
//   and req.ready drops once both queue entries are occupied.
//   Reset: arst_n clears the queue, the result valid flag, the held word and
//   the bit position; the first read starts on a fresh word.
// ----------------------------------------------------------------------------
module bit_field_reader_unit import bfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bfr_req_if.sink   req,
	bfr_rsp_if.source rsp
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// classification
	bfr_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	bfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// execution and result register
	bfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/bfr_front.sv =====
// ----------------------------------------------------------------------------
// bfr_front
// Accepts request items, saturates the width and classifies each item as
// read, pad or no-op before it enters the queue.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; (
	bfr_req_if.sink  req,
	output logic     push_valid,
	input  logic     push_ready,
	output cmd_t     push_cmd
);

	logic [63:0] word_ext;

	// handshake passes straight to the queue
	assign push_valid = req.valid;
	assign req.ready  = push_ready;

	// classify and normalize
	always_comb begin
		word_ext = {32'b0, req.next_word};
		push_cmd.word  = word_ext[WORD_BITS-1:0];
		push_cmd.avail = req.word_available;
		if (req.field_width > FW_W'(FIELD_MAX)) begin
			push_cmd.width = N_W'(FIELD_MAX);
		end else begin
			push_cmd.width = N_W'(req.field_width);
		end
		if (req.operation == OP_PAD) begin
			push_cmd.kind = KIND_PAD;
		end else if (req.field_width == '0) begin
			push_cmd.kind = KIND_SKIP;
		end else begin
			push_cmd.kind = KIND_READ;
		end
	end

endmodule

// ===== hw/rtl/bfr_queue.sv =====
// ----------------------------------------------------------------------------
// bfr_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module bfr_queue import bfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// fill level stays within the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill level out of range");

	// a push into a full queue never completes
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(QUEUE_DEPTH)) && !do_pop |=> count_q == QCNT_W'(QUEUE_DEPTH))
		else $error("queue overflow");

endmodule

// ===== hw/rtl/bfr_back.sv =====
// ----------------------------------------------------------------------------
// bfr_back
// Carries out queued items against the held word remainder and bit position
// and registers one result per item.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  cmd_t     pop_cmd,
	bfr_rsp_if.source rsp
);

	logic [WORD_BITS-1:0]   rem_q;
	logic [POS_W-1:0]       pos_q;
	logic                   out_valid_q;
	logic [VALUE_W-1:0]     value_q;
	logic                   taken_q;
	logic                   short_q;

	logic                   do_pop;
	logic [CNT_W-1:0]       left;
	logic [CNT_W-1:0]       n_ext;
	logic [CNT_W:0]         pos_sum;
	logic [CNT_W-1:0]       tail;
	logic                   need;
	logic                   take;
	logic                   short_of;
	logic [WORD_BITS-1:0]   word_in;
	logic [2*WORD_BITS-1:0] cat;
	logic [2*WORD_BITS-1:0] shifted;
	logic [2*WORD_BITS-1:0] advanced;
	logic [2*WORD_BITS+31:0] value_ext;
	logic [SH_W-1:0]        sh;
	logic [VALUE_W-1:0]     value_d;
	logic [WORD_BITS-1:0]   rem_d;
	logic [POS_W-1:0]       pos_d;

	assign do_pop    = pop_valid && pop_ready;
	assign pop_ready = !out_valid_q || rsp.ready;

	// field extraction: word placed right after the unread head bits
	always_comb begin
		n_ext    = CNT_W'(pop_cmd.width);
		left     = (pos_q == '0) ? '0 : CNT_W'(WORD_BITS) - CNT_W'(pos_q);
		need     = (pop_cmd.kind == KIND_READ) && (n_ext > left);
		take     = need && pop_cmd.avail;
		short_of = need && !pop_cmd.avail;
		word_in  = take ? pop_cmd.word : '0;
		cat      = {rem_q, {WORD_BITS{1'b0}}} | ({word_in, {WORD_BITS{1'b0}}} >> left);
		sh       = SH_W'(2 * WORD_BITS) - SH_W'(pop_cmd.width);
		shifted  = cat >> sh;
		advanced = cat << pop_cmd.width;
		value_ext = {32'b0, shifted};
		pos_sum  = {1'b0, CNT_W'(pos_q)} + {1'b0, n_ext};
		tail     = n_ext - left;

		value_d = '0;
		rem_d   = rem_q;
		pos_d   = pos_q;
		unique case (pop_cmd.kind)
			KIND_PAD: begin
				rem_d = '0;
				pos_d = '0;
			end
			KIND_READ: begin
				value_d = value_ext[VALUE_W-1:0];
				rem_d   = advanced[2*WORD_BITS-1 -: WORD_BITS];
				if (short_of) begin
					rem_d = '0;
					pos_d = '0;
				end else if (take) begin
					pos_d = (tail == CNT_W'(WORD_BITS)) ? '0 : POS_W'(tail);
				end else begin
					pos_d = (pos_sum >= (CNT_W + 1)'(WORD_BITS)) ? '0 : POS_W'(pos_sum);
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
	end

	// control state and held word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			pos_q       <= '0;
		end else begin
			if (do_pop) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_d;
				pos_q       <= pos_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (do_pop) begin
			value_q <= value_d;
			taken_q <= take;
			short_q <= short_of;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.field_value = value_q;
	assign rsp.word_taken  = taken_q;
	assign rsp.ran_out     = short_q;

	// an empty position always comes with an empty remainder
	a_empty_rem: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> rem_q == '0)
		else $error("remainder not empty at word boundary");

	// a result never both takes a word and runs out
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(taken_q && short_q))
		else $error("word_taken and ran_out both set");

	// running out leaves the reader at a word boundary
	a_short_empty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && short_of |=> pos_q == '0)
		else $error("state not empty after ran_out");

	// state moves only when an item is executed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_pop |=> $stable(pos_q) && $stable(rem_q))
		else $error("state changed without an item");

endmodule
